FILE: rtl/core/aarr_pkg.sv
// Shared types and constants of the area-average row resampler.
// Holds the word structs of both streams and the register map constants.
// No dependencies.
package aarr_pkg;

  // Default build sizes.
  localparam int unsigned MAX_WIDTH_DEF   = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Channel field width of both streams.
  localparam int unsigned FIELD_BITS = 16;

  // Width register size and register bus sizes.
  localparam int unsigned CFG_REG_BITS  = 13;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_SOURCE_WIDTH = 1'b0;
  localparam logic REG_TARGET_WIDTH = 1'b1;

  // At most this many output words are sent for one input word.
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_BITS    = $clog2(MAX_RESULTS + 1);

  // One source pixel.
  typedef struct packed {
    logic [FIELD_BITS-1:0] chan_a;
    logic [FIELD_BITS-1:0] chan_b;
    logic [FIELD_BITS-1:0] chan_c;
    logic [FIELD_BITS-1:0] chan_d;
  } in_word_t;

  // One resampled pixel with its row and run markers.
  typedef struct packed {
    logic [FIELD_BITS-1:0] out_a;
    logic [FIELD_BITS-1:0] out_b;
    logic [FIELD_BITS-1:0] out_c;
    logic [FIELD_BITS-1:0] out_d;
    logic                  row_end;
    logic                  run_end;
  } out_word_t;

endpackage

FILE: rtl/core/area_average_row_resampler_top.sv
// Top level of the area-average row resampler: sequencer, shared multiply-accumulate
// and shared four-lane restoring divider. Depends on aarr_pkg.
//
//   Port group      Direction  Handshake                   Payload
//   in_*            input      in_valid_i / in_stall_o     in_word_i  (aarr_pkg::in_word_t)
//   out_*           output     out_valid_o / out_stall_i   out_word_o (aarr_pkg::out_word_t)
//   p* (APB)        config     psel, penable, pwrite       paddr, pwdata, prdata
//
// An input word goes through check, multiply-accumulate, divider load, divide and emit for
// every output word it sends, and through one more multiply-accumulate when it leaves a
// partial sum for the next output; outputs past the first 64 are skipped. Its time is set
// by the single multiplier, used once per channel, and by the divider, which retires one
// quotient bit per cycle for all four channels. The input is stalled for the whole item.
// A result waits in the output register while the block goes on with its work; it only holds
// the sequencer when a new result is ready and the old one has not been taken. Reset sets both
// widths to one and restarts the row; every register write also restarts the row.
module area_average_row_resampler_top #(
  parameter int unsigned MAX_WIDTH   = aarr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned SAMPLE_BITS = aarr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  aarr_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output aarr_pkg::out_word_t                  out_word_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [aarr_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [aarr_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [aarr_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import aarr_pkg::*;

  // Width of a clamped row width, of a position on the common axis, of a channel sum.
  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AB  = 2 * WB + 1;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned NB  = WB + SB;
  localparam int unsigned DCB = $clog2(SB);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MAC    = 3'd2;
  localparam logic [2:0] ST_DLOAD  = 3'd3;
  localparam logic [2:0] ST_DIVIDE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // Maps a width register to 1..MAX_WIDTH.
  function automatic logic [WB-1:0] clamp_width(input logic [CFG_REG_BITS-1:0] w);
    logic [31:0] w32;
    w32 = 32'(w);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > MAX_WIDTH) begin
      w32 = MAX_WIDTH;
    end
    return WB'(w32);
  endfunction

  logic [2:0]              state_q, state_d;
  logic [CFG_REG_BITS-1:0] src_w_q, src_w_d;
  logic [CFG_REG_BITS-1:0] dst_w_q, dst_w_d;
  logic [WB-1:0]           in_col_q, in_col_d;
  logic [WB-1:0]           out_col_q, out_col_d;
  logic [AB-1:0]           lo_q, lo_d;
  logic [AB-1:0]           hi_q, hi_d;
  logic [AB-1:0]           cur_q, cur_d;
  logic [AB-1:0]           bnd_q, bnd_d;
  logic [NB-1:0]           sums_q [4];
  logic [NB-1:0]           sums_d [4];
  logic [SB-1:0]           sample_q [4];
  logic [SB-1:0]           sample_d [4];
  logic [WB-1:0]           ovl_q, ovl_d;
  logic [1:0]              lane_q, lane_d;
  logic                    tail_q, tail_d;
  logic [DCB-1:0]          div_cnt_q, div_cnt_d;
  logic [NB-1:0]           rem_q [4];
  logic [NB-1:0]           rem_d [4];
  logic [SB-1:0]           quot_q [4];
  logic [SB-1:0]           quot_d [4];
  logic [NB-1:0]           dsr_q, dsr_d;
  logic [RES_BITS-1:0]     res_cnt_q, res_cnt_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic [WB-1:0]           s_w, t_w;
  logic                    cfg_wr;
  logic                    cfg_idx;
  logic [NB-1:0]           mac_prod;
  logic [WB:0]             col_next;
  logic [AB-1:0]           bnd_next;
  logic                    more;
  logic                    can_load;

  assign s_w     = clamp_width(src_w_q);
  assign t_w     = clamp_width(dst_w_q);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_ADDR_BITS-1];

  // Register bus: always ready, reads return the raw register.
  assign pready = 1'b1;
  assign prdata = (cfg_idx == REG_SOURCE_WIDTH) ? APB_DATA_BITS'(src_w_q)
                                                : APB_DATA_BITS'(dst_w_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Shared multiplier: one channel of overlap times sample per cycle.
  assign mac_prod = NB'(ovl_q) * NB'(sample_q[lane_q]);

  // Look-ahead for the output being sent: does another output follow for this input?
  assign col_next = {1'b0, out_col_q} + (WB + 1)'(1);
  assign bnd_next = bnd_q + AB'(s_w);
  assign more     = (col_next != {1'b0, t_w}) && (bnd_next <= hi_q)
                    && (res_cnt_q != RES_BITS'(MAX_RESULTS - 1));
  assign can_load = !out_valid_q || !out_stall_i;

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    src_w_d     = src_w_q;
    dst_w_d     = dst_w_q;
    in_col_d    = in_col_q;
    out_col_d   = out_col_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    bnd_d       = bnd_q;
    sums_d      = sums_q;
    sample_d    = sample_q;
    ovl_d       = ovl_q;
    lane_d      = lane_q;
    tail_d      = tail_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    dsr_d       = dsr_q;
    res_cnt_d   = res_cnt_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sample_d[0] = SB'(in_word_i.chan_a);
          sample_d[1] = SB'(in_word_i.chan_b);
          sample_d[2] = SB'(in_word_i.chan_c);
          sample_d[3] = SB'(in_word_i.chan_d);
          hi_d        = lo_q + AB'(t_w);
          cur_d       = lo_q;
          res_cnt_d   = '0;
          state_d     = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if ((out_col_q < t_w) && (bnd_q <= hi_q)) begin
          if (res_cnt_q < RES_BITS'(MAX_RESULTS)) begin
            // An output closes inside this input: add its last piece.
            ovl_d   = WB'(bnd_q - cur_q);
            lane_d  = '0;
            tail_d  = 1'b0;
            state_d = ST_MAC;
          end else begin
            // Past the result limit: the output is skipped, the row moves on.
            out_col_d = out_col_q + WB'(1);
            cur_d     = bnd_q;
            bnd_d     = bnd_next;
          end
        end else if ((cur_q < hi_q) && (out_col_q < t_w)) begin
          // The rest of the input goes into the next output's partial sums.
          ovl_d   = WB'(hi_q - cur_q);
          lane_d  = '0;
          tail_d  = 1'b1;
          state_d = ST_MAC;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_MAC: begin
        sums_d[lane_q] = sums_q[lane_q] + mac_prod;
        lane_d         = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          state_d = tail_q ? ST_FINISH : ST_DLOAD;
        end
      end

      ST_DLOAD: begin
        // Add half the divisor for round-to-nearest, then start the division.
        for (int i = 0; i < 4; i++) begin
          rem_d[i]  = sums_q[i] + NB'(s_w >> 1);
          quot_d[i] = '0;
          sums_d[i] = '0;
        end
        dsr_d     = NB'(s_w) << (SB - 1);
        div_cnt_d = DCB'(SB - 1);
        state_d   = ST_DIVIDE;
      end

      ST_DIVIDE: begin
        // One quotient bit per lane per cycle, divisor walks right.
        for (int i = 0; i < 4; i++) begin
          if (rem_q[i] >= dsr_q) begin
            rem_d[i]  = rem_q[i] - dsr_q;
            quot_d[i] = {quot_q[i][SB-2:0], 1'b1};
          end else begin
            quot_d[i] = {quot_q[i][SB-2:0], 1'b0};
          end
        end
        dsr_d     = dsr_q >> 1;
        div_cnt_d = div_cnt_q - DCB'(1);
        if (div_cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (can_load) begin
          out_word_d.out_a   = FIELD_BITS'(quot_q[0]);
          out_word_d.out_b   = FIELD_BITS'(quot_q[1]);
          out_word_d.out_c   = FIELD_BITS'(quot_q[2]);
          out_word_d.out_d   = FIELD_BITS'(quot_q[3]);
          out_word_d.row_end = (col_next == {1'b0, t_w});
          out_word_d.run_end = !more;
          out_valid_d        = 1'b1;
          out_col_d          = WB'(col_next);
          cur_d              = bnd_q;
          bnd_d              = bnd_next;
          res_cnt_d          = res_cnt_q + RES_BITS'(1);
          state_d            = ST_CHECK;
        end
      end

      ST_FINISH: begin
        if (in_col_q + WB'(1) == s_w) begin
          // Last source pixel of the row: start the next row.
          in_col_d  = '0;
          out_col_d = '0;
          lo_d      = '0;
          bnd_d     = AB'(s_w);
          for (int i = 0; i < 4; i++) begin
            sums_d[i] = '0;
          end
        end else begin
          in_col_d = in_col_q + WB'(1);
          lo_d     = hi_q;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write restarts the row with the new widths.
    if (cfg_wr) begin
      if (cfg_idx == REG_SOURCE_WIDTH) begin
        src_w_d = CFG_REG_BITS'(pwdata);
        bnd_d   = AB'(clamp_width(CFG_REG_BITS'(pwdata)));
      end else begin
        dst_w_d = CFG_REG_BITS'(pwdata);
        bnd_d   = AB'(s_w);
      end
      in_col_d  = '0;
      out_col_d = '0;
      lo_d      = '0;
      for (int i = 0; i < 4; i++) begin
        sums_d[i] = '0;
      end
    end
  end

  // Control and row state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_w_q     <= CFG_REG_BITS'(1);
      dst_w_q     <= CFG_REG_BITS'(1);
      in_col_q    <= '0;
      out_col_q   <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      cur_q       <= '0;
      bnd_q       <= AB'(1);
      lane_q      <= '0;
      tail_q      <= 1'b0;
      div_cnt_q   <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      src_w_q     <= src_w_d;
      dst_w_q     <= dst_w_d;
      in_col_q    <= in_col_d;
      out_col_q   <= out_col_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      cur_q       <= cur_d;
      bnd_q       <= bnd_d;
      lane_q      <= lane_d;
      tail_q      <= tail_d;
      div_cnt_q   <= div_cnt_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
      sums_q      <= sums_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    ovl_q      <= ovl_d;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    dsr_q      <= dsr_d;
    out_word_q <= out_word_d;
  end

endmodule

FILE: rtl/core/aarr_checker.sv
// Port-level checks for the area-average row resampler, bound to its top level.
// Depends on aarr_pkg and area_average_row_resampler_top.
module aarr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input aarr_pkg::out_word_t out_word_o
);
  import aarr_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Once a pixel is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without a busy cycle");

  // A new output word only appears while a pixel is being worked on.
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word appeared while idle");

  // The last pixel of a row always closes the run of its input.
  a_row_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.row_end |-> out_word_o.run_end)
    else $error("row end without run end");

endmodule

bind area_average_row_resampler_top aarr_checker u_aarr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
